// ===== design/pwc_pkg.sv =====
// Shared types and constants for the page erase wear counter.
`timescale 1ns / 1ps
package pwc_pkg;

  localparam int PAGES_DEF     = 64;
  localparam int TALLY_LEN_DEF = 7;
  localparam int COUNT_W       = 16;
  localparam int PAGE_FIELD_W  = 6;
  // tally (<= 255) plus at most two increments
  localparam int ADDEND_W      = 9;

  localparam logic [COUNT_W-1:0] BASE_ERASED = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ZERO  = 16'h0000;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } pwc_op_t;

  typedef struct packed {
    pwc_op_t                 operation;
    logic [PAGE_FIELD_W-1:0] page;
  } pwc_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] page_count;
    logic               consolidated;
  } pwc_rsp_t;

endpackage

// ===== design/pwc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module pwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pwc_alu.sv =====
// Shared adder: base plus addend, and that sum plus one.
`timescale 1ns / 1ps
module pwc_alu import pwc_pkg::*; (
  input  logic [COUNT_W-1:0]  base,
  input  logic [ADDEND_W-1:0] addend,
  output logic [COUNT_W-1:0]  sum,
  output logic [COUNT_W-1:0]  sum_inc
);

  assign sum     = base + COUNT_W'(addend);
  assign sum_inc = sum + COUNT_W'(1);

endmodule

// ===== design/page_erase_wear_counter_top.sv =====
// Top level of the per-page flash erase wear counter with tally marks.
//
//  channel | ports                    | handshake
//  --------+--------------------------+-------------------------------------
//  request | start, busy, in_req      | taken at edge with start && !busy
//  result  | out_valid, out_rsp       | one-cycle strobe, never held off
//
// Flow: a read or a record with room in the tally does the RAM read, then the
// update and answer in LOOK; the result strobe shows in the cycle after LOOK.
// A page beyond PAGES is answered at once with a zero count.
// A consolidating record walks the whole entry RAM through its single read
// port and single write port, busy throughout.
// Reset: synchronous, active low; clears the per-page valid bits, so every
// page reads as base 0xFFFF, tally 0 without touching the RAM.
// Stalls: the receiver cannot stall; busy only reflects the sequencer.
`timescale 1ns / 1ps
module page_erase_wear_counter_top import pwc_pkg::*; #(
  parameter int PAGES     = PAGES_DEF,
  parameter int TALLY_LEN = TALLY_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pwc_req_t in_req,
  output logic     out_valid,
  output pwc_rsp_t out_rsp
);

  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int TW     = $clog2(TALLY_LEN + 1);
  localparam int ENT_W  = COUNT_W + TW;
  localparam logic [PAGE_W-1:0] COUNTER_PAGE = PAGE_W'(PAGES - 1);
  localparam logic [TW-1:0]     TALLY_MAX = TW'(TALLY_LEN);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,   // RAM data for the requested page is present
    ST_FOLD  = 4'b0100,   // issuing reads across all pages
    ST_DRAIN = 4'b1000    // last write-back, answer
  } pwc_state_t;

  pwc_state_t state_r, state_nxt;

  // request capture
  pwc_op_t             op_r;
  logic [PAGE_W-1:0]   page_addr_r;

  // fold walk
  logic [PAGE_W-1:0]   idx_r, idx_nxt;
  logic                wb_v_r, wb_v_nxt;
  logic [PAGE_W-1:0]   wb_addr_r;
  logic [COUNT_W-1:0]  cap_r, cap_nxt;

  // valid bits: an entry not yet written holds erased base and no marks
  logic [PAGES-1:0]    valid_r, valid_nxt;

  logic                out_valid_r, out_valid_nxt;
  pwc_rsp_t            out_rsp_r, out_rsp_nxt;

  // RAM
  logic                ram_we;
  logic [PAGE_W-1:0]   ram_waddr, ram_raddr;
  logic [ENT_W-1:0]    ram_wdata, ram_rdata;

  // current entry as seen by LOOK or write-back
  logic [PAGE_W-1:0]   ent_addr;
  logic                ent_valid;
  logic [COUNT_W-1:0]  ent_base;
  logic [TW-1:0]       ent_tally;

  // shared adder
  logic [ADDEND_W-1:0] alu_addend;
  logic [COUNT_W-1:0]  alu_sum, alu_sum_inc;

  logic                in_fire;
  logic                in_page_ok;
  logic [PAGE_W-1:0]   in_page_addr;
  logic [ADDEND_W-1:0] wb_inc;

  assign busy      = (state_r != ST_IDLE);
  assign in_fire   = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign in_page_ok   = (32'(in_req.page) < 32'(PAGES));
  assign in_page_addr = PAGE_W'(in_req.page);

  assign ent_addr  = wb_v_r ? wb_addr_r : page_addr_r;
  assign ent_valid = valid_r[ent_addr];
  assign ent_base  = ent_valid ? ram_rdata[ENT_W-1:TW] : BASE_ERASED;
  assign ent_tally = ent_valid ? ram_rdata[TW-1:0] : TW'(0);

  // the counter page and the recorded page each gain one on a fold
  assign wb_inc = ADDEND_W'(wb_addr_r == COUNTER_PAGE) + ADDEND_W'(wb_addr_r == page_addr_r);

  pwc_ram #(
    .WIDTH (ENT_W),
    .DEPTH (PAGES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pwc_alu u_alu (
    .base    (ent_base),
    .addend  (alu_addend),
    .sum     (alu_sum),
    .sum_inc (alu_sum_inc)
  );

  assign ram_raddr = (state_r == ST_IDLE) ? in_page_addr : idx_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wb_v_nxt      = 1'b0;
    cap_nxt       = cap_r;
    valid_nxt     = valid_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    ram_we        = 1'b0;
    ram_waddr     = ent_addr;
    ram_wdata     = {ent_base, ent_tally};
    alu_addend    = ADDEND_W'(ent_tally) + ADDEND_W'(1);

    // fold write-back: base absorbs tally (plus increments), tally cleared
    if (wb_v_r) begin
      alu_addend = ADDEND_W'(ent_tally) + wb_inc;
      ram_we     = 1'b1;
      ram_wdata  = {alu_sum, TW'(0)};
      valid_nxt[wb_addr_r] = 1'b1;
      if (wb_addr_r == page_addr_r) begin
        cap_nxt = alu_sum_inc;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_page_ok) begin
            state_nxt = ST_LOOK;
          end else begin
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '{page_count: COUNT_ZERO, consolidated: 1'b0};
          end
        end
      end
      ST_LOOK: begin
        if (op_r == OP_READ) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{page_count: alu_sum, consolidated: 1'b0};
          state_nxt     = ST_IDLE;
        end else if (ent_tally < TALLY_MAX) begin
          // one more mark; answer 1 + base + new tally
          alu_addend    = ADDEND_W'(ent_tally) + ADDEND_W'(2);
          ram_we        = 1'b1;
          ram_wdata     = {ent_base, ent_tally + TW'(1)};
          valid_nxt[page_addr_r] = 1'b1;
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{page_count: alu_sum, consolidated: 1'b0};
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        wb_v_nxt = 1'b1;
        if (idx_r == COUNTER_PAGE) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + PAGE_W'(1);
        end
      end
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{page_count: (wb_addr_r == page_addr_r) ? alu_sum_inc : cap_r,
                          consolidated: 1'b1};
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wb_v_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wb_v_r      <= wb_v_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r        <= in_req.operation;
      page_addr_r <= in_page_addr;
    end
    idx_r     <= idx_nxt;
    wb_addr_r <= idx_r;
    cap_r     <= cap_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // write-back only happens during the fold walk
  a_wb_in_fold: assert property (@(posedge clk) disable iff (!rst_n)
    wb_v_r |-> (state_r == ST_FOLD || state_r == ST_DRAIN))
    else $error("fold write-back outside fold walk");

  // RAM writes come from the LOOK update or the fold write-back
  a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_LOOK || wb_v_r))
    else $error("unexpected RAM write");

  // a consolidated answer means every page has been rewritten
  a_fold_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.consolidated) |-> (&valid_r))
    else $error("fold finished with unwritten pages");

  // an accepted request either makes the block busy or answers at once
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (busy || out_valid_r))
    else $error("request accepted but dropped");

endmodule
